// ===== rtl/bufr_pkg.sv =====
// ----------------------------------------------------------------------------
// bufr_pkg: shared types and constants for the batched update frame receiver
// Holds the transaction payload types, frame codes and the divider interface.
// ----------------------------------------------------------------------------
package bufr_pkg;

  localparam int STREAM_ADDR_BITS = 32;

  localparam logic [7:0] MAGIC_HOST0     = 8'h80;
  localparam logic [7:0] MAGIC_HOST1     = 8'h00;
  localparam logic [7:0] MAGIC_HOST2     = 8'hee;
  localparam logic [7:0] MAGIC_DEV0      = 8'h81;
  localparam logic [15:0] RESP_FIXED_LEN = 16'd7;
  localparam logic [15:0] DATA_FIXED_LEN = 16'd11;
  localparam logic [15:0] META_LENGTH    = 16'd17;
  localparam logic [7:0] FTYPE_META      = 8'd1;
  localparam logic [7:0] FTYPE_DATA      = 8'd3;
  localparam logic [7:0] RTYPE_ACK       = 8'd2;
  localparam logic [7:0] RTYPE_TERM      = 8'd5;
  localparam logic [2:0] BAD_LIMIT_RESET = 3'd5;
  localparam logic [2:0] BAD_COUNT_MAX   = 3'd7;

  localparam logic [1:0] KIND_STREAM = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] stream_address;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/batched_update_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// batched_update_frame_receiver: host update frame parser
// Parses host frames byte by byte, streams payload and serializes responses.
// ----------------------------------------------------------------------------
// One frame byte is taken per transaction. Bytes that produce no result or a
// single result (payload write, transfer complete) are taken at one per cycle
// as long as the consumer keeps up; the result register holds the input off
// only while a result waits under out_stall. A byte that closes a frame with
// an ack or a terminal frame stalls the input while the 11-byte or 8-byte
// response is loaded, one response byte per cycle while out_stall is low,
// and the next byte is taken once the last response byte is loaded. A good
// metadata frame first runs the serial divider for the packet count: a
// load and 33 iterations, and the sequencer waits for the divider to finish
// before the ack starts. The bad frame limit register may be written at any
// idle time and takes effect on the next bad frame.
module batched_update_frame_receiver
  import bufr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RESP = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  limit_r, limit_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [7:0]  fkind_r, fkind_nxt;
  logic        mok_r, mok_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] pnum_r, pnum_nxt;
  logic [15:0] psize_r, psize_nxt;
  logic [31:0] tsize_r, tsize_nxt;
  logic [15:0] bsize_r, bsize_nxt;
  logic [31:0] ptotal_r, ptotal_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] bfirst_r, bfirst_nxt;
  logic [31:0] fill_r, fill_nxt;
  logic [31:0] bstart_r, bstart_nxt;
  logic [15:0] bpos_r, bpos_nxt;
  logic [2:0]  bad_r, bad_nxt;
  logic [15:0] npsize_r, npsize_nxt;
  logic [15:0] nbsize_r, nbsize_nxt;
  // Response serializer: type, payload word, byte index, checksum.
  logic        rterm_r, rterm_nxt;
  logic [31:0] rword_r, rword_nxt;
  logic [3:0]  ridx_r, ridx_nxt;
  logic [7:0]  rsum_r, rsum_nxt;
  logic        ovalid_r, ovalid_nxt;
  out_item_t   odata_r, odata_nxt;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        in_acc;
  logic [15:0] p;
  logic [7:0]  b;
  logic [7:0]  rbyte;
  logic [3:0]  rlen_m1;
  logic [2:0]  bad_inc;
  logic [31:0] stream_mask;

  bufr_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (dreq),
    .rsp (drsp)
  );

  assign stream_mask = 32'hffff_ffff >> (32 - STREAM_ADDR_BITS);
  assign in_stall    = !(state_r == ST_IDLE) || (ovalid_r && out_stall);
  assign in_acc      = in_valid && !in_stall;
  assign b           = in_data.frame_byte;
  assign p           = pos_r + 16'd1;
  assign rlen_m1     = rterm_r ? 4'd7 : 4'd10;
  assign bad_inc     = (bad_r < BAD_COUNT_MAX) ? bad_r + 3'd1 : bad_r;

  // Response byte at the current index.
  always_comb begin
    case (ridx_r)
      4'd0: rbyte = MAGIC_DEV0;
      4'd1: rbyte = 8'h00;
      4'd2: rbyte = 8'hee;
      4'd3: rbyte = rterm_r ? RTYPE_TERM : RTYPE_ACK;
      4'd4: rbyte = rterm_r ? 8'd8 : 8'd11;
      4'd5: rbyte = 8'h00;
      4'd6: rbyte = rterm_r ? 8'h00 : rword_r[7:0];
      4'd7: rbyte = rterm_r ? rsum_r : rword_r[15:8];
      4'd8: rbyte = rword_r[23:16];
      4'd9: rbyte = rword_r[31:24];
      default: rbyte = rsum_r;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    limit_nxt  = limit_r;
    pos_nxt    = pos_r;
    dlen_nxt   = dlen_r;
    fkind_nxt  = fkind_r;
    mok_nxt    = mok_r;
    sum_nxt    = sum_r;
    pnum_nxt   = pnum_r;
    psize_nxt  = psize_r;
    tsize_nxt  = tsize_r;
    bsize_nxt  = bsize_r;
    ptotal_nxt = ptotal_r;
    exp_nxt    = exp_r;
    bfirst_nxt = bfirst_r;
    fill_nxt   = fill_r;
    bstart_nxt = bstart_r;
    bpos_nxt   = bpos_r;
    bad_nxt    = bad_r;
    npsize_nxt = npsize_r;
    nbsize_nxt = nbsize_r;
    rterm_nxt  = rterm_r;
    rword_nxt  = rword_r;
    ridx_nxt   = ridx_r;
    rsum_nxt   = rsum_r;
    ovalid_nxt = ovalid_r && out_stall;
    odata_nxt  = odata_r;
    dreq.start    = 1'b0;
    dreq.dividend = tsize_r;
    dreq.divisor  = psize_r;

    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.frame_start) begin
            pos_nxt   = '0;
            sum_nxt   = b;
            mok_nxt   = (b == MAGIC_HOST0);
            fkind_nxt = '0;
            dlen_nxt  = '0;
          end else if (mok_r) begin
            pos_nxt = p;
            if (p <= 16'd5) begin
              sum_nxt = sum_r + b;
              if (p == 16'd1 && b != MAGIC_HOST1) begin
                mok_nxt = 1'b0;
              end else if (p == 16'd2 && b != MAGIC_HOST2) begin
                mok_nxt = 1'b0;
              end else if (p == 16'd3) begin
                fkind_nxt = b;
                if (b != FTYPE_META && b != FTYPE_DATA) mok_nxt = 1'b0;
              end else if (p == 16'd4) begin
                dlen_nxt = {8'd0, b};
              end else if (p == 16'd5) begin
                dlen_nxt = {b, dlen_r[7:0]};
                if (fkind_r == FTYPE_META && {b, dlen_r[7:0]} < META_LENGTH) begin
                  mok_nxt = 1'b0;
                end else if (fkind_r == FTYPE_DATA &&
                             {b, dlen_r[7:0]} < DATA_FIXED_LEN) begin
                  mok_nxt = 1'b0;
                  // Short data frame counts as bad.
                  bad_nxt = bad_inc;
                  ridx_nxt = '0;
                  state_nxt = ST_RESP;
                  if (bad_inc >= limit_r) begin
                    rterm_nxt = 1'b1;
                  end else begin
                    rterm_nxt = 1'b0;
                    rword_nxt = bfirst_r;
                    exp_nxt   = bfirst_r;
                    fill_nxt  = bstart_r;
                    bpos_nxt  = '0;
                  end
                end
              end
            end else if (p == dlen_r - 16'd1) begin
              mok_nxt = 1'b0;
              if (fkind_r == FTYPE_META) begin
                if (npsize_r != 16'd0 && nbsize_r != 16'd0) begin
                  psize_nxt  = npsize_r;
                  bsize_nxt  = nbsize_r;
                  tsize_nxt  = pnum_r;
                  dreq.start = 1'b1;
                  dreq.dividend = pnum_r;
                  dreq.divisor  = npsize_r;
                  exp_nxt    = '0;
                  bfirst_nxt = '0;
                  fill_nxt   = '0;
                  bstart_nxt = '0;
                  bpos_nxt   = '0;
                  bad_nxt    = '0;
                  rterm_nxt  = 1'b0;
                  rword_nxt  = '0;
                  ridx_nxt   = '0;
                  state_nxt  = ST_DIV;
                end
              end else if (sum_r != b || pnum_r != exp_r) begin
                bad_nxt  = bad_inc;
                ridx_nxt = '0;
                state_nxt = ST_RESP;
                if (bad_inc >= limit_r) begin
                  rterm_nxt = 1'b1;
                end else begin
                  rterm_nxt = 1'b0;
                  rword_nxt = bfirst_r;
                  exp_nxt   = bfirst_r;
                  fill_nxt  = bstart_r;
                  bpos_nxt  = '0;
                end
              end else begin
                fill_nxt = fill_r + {16'd0, dlen_r - DATA_FIXED_LEN};
                exp_nxt  = exp_r + 32'd1;
                bad_nxt  = '0;
                bpos_nxt = bpos_r + 16'd1;
                if (ptotal_r != 32'd0 && pnum_r == ptotal_r - 32'd1) begin
                  ovalid_nxt = 1'b1;
                  odata_nxt.kind = KIND_DONE;
                  odata_nxt.byte_value = '0;
                  odata_nxt.stream_address =
                    (fill_r + {16'd0, dlen_r - DATA_FIXED_LEN}) & stream_mask;
                  odata_nxt.last = 1'b1;
                end else if (bsize_r != 16'd0 && bpos_r + 16'd1 == bsize_r) begin
                  rterm_nxt  = 1'b0;
                  rword_nxt  = exp_r + 32'd1;
                  ridx_nxt   = '0;
                  bfirst_nxt = exp_r + 32'd1;
                  bstart_nxt = fill_r + {16'd0, dlen_r - DATA_FIXED_LEN};
                  bpos_nxt   = '0;
                  state_nxt  = ST_RESP;
                end
              end
            end else begin
              sum_nxt = sum_r + b;
              if (fkind_r == FTYPE_META) begin
                case (p)
                  16'd6:  npsize_nxt = {8'd0, b};
                  16'd7:  npsize_nxt = {b, npsize_r[7:0]};
                  16'd8:  pnum_nxt = {24'd0, b};
                  16'd9:  pnum_nxt[15:8] = b;
                  16'd10: pnum_nxt[23:16] = b;
                  16'd11: pnum_nxt[31:24] = b;
                  16'd12: nbsize_nxt = {8'd0, b};
                  16'd13: nbsize_nxt = {b, nbsize_r[7:0]};
                  default: ;
                endcase
              end else if (p == 16'd6) begin
                pnum_nxt = {24'd0, b};
              end else if (p == 16'd7) begin
                pnum_nxt[15:8] = b;
              end else if (p == 16'd8) begin
                pnum_nxt[23:16] = b;
              end else if (p == 16'd9) begin
                pnum_nxt[31:24] = b;
              end else if (pnum_r == exp_r) begin
                ovalid_nxt = 1'b1;
                odata_nxt.kind = KIND_STREAM;
                odata_nxt.byte_value = b;
                odata_nxt.stream_address =
                  (fill_r + {16'd0, p - 16'd10}) & stream_mask;
                odata_nxt.last = 1'b0;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          ptotal_nxt = drsp.quotient;
          state_nxt  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          odata_nxt.kind = KIND_RESP;
          odata_nxt.byte_value = rbyte;
          odata_nxt.stream_address = '0;
          odata_nxt.last = (ridx_r == rlen_m1);
          rsum_nxt = (ridx_r == 4'd0) ? rbyte : rsum_r + rbyte;
          ridx_nxt = ridx_r + 4'd1;
          if (ridx_r == rlen_m1) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    rword_r <= rword_nxt;
    rsum_r  <= rsum_nxt;
    rterm_r <= rterm_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      limit_r  <= BAD_LIMIT_RESET;
      pos_r    <= '0;
      dlen_r   <= '0;
      fkind_r  <= '0;
      mok_r    <= 1'b0;
      sum_r    <= '0;
      pnum_r   <= '0;
      psize_r  <= '0;
      tsize_r  <= '0;
      bsize_r  <= '0;
      ptotal_r <= '0;
      exp_r    <= '0;
      bfirst_r <= '0;
      fill_r   <= '0;
      bstart_r <= '0;
      bpos_r   <= '0;
      bad_r    <= '0;
      npsize_r <= '0;
      nbsize_r <= '0;
      ridx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      limit_r  <= limit_nxt;
      pos_r    <= pos_nxt;
      dlen_r   <= dlen_nxt;
      fkind_r  <= fkind_nxt;
      mok_r    <= mok_nxt;
      sum_r    <= sum_nxt;
      pnum_r   <= pnum_nxt;
      psize_r  <= psize_nxt;
      tsize_r  <= tsize_nxt;
      bsize_r  <= bsize_nxt;
      ptotal_r <= ptotal_nxt;
      exp_r    <= exp_nxt;
      bfirst_r <= bfirst_nxt;
      fill_r   <= fill_nxt;
      bstart_r <= bstart_nxt;
      bpos_r   <= bpos_nxt;
      bad_r    <= bad_nxt;
      npsize_r <= npsize_nxt;
      nbsize_r <= nbsize_nxt;
      ridx_r   <= ridx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // The divider only runs while the sequencer waits on it.
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.busy |-> state_r == ST_DIV) else $error("divider busy outside wait");

  // Input is never taken while a response frame is being serialized.
  a_no_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESP |-> in_stall) else $error("input open during response");

  // The last flag of a response byte closes the response state.
  a_resp_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && (!ovalid_r || !out_stall) && ridx_r == rlen_m1)
    |=> state_r == ST_IDLE && out_data.last) else $error("response end lost");

endmodule

// ===== rtl/bufr_div.sv =====
// ----------------------------------------------------------------------------
// bufr_div: iterative divider
// Restoring division, one quotient bit per cycle, 33-bit dividend.
// ----------------------------------------------------------------------------
module bufr_div
  import bufr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [32:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;
  logic [32:0] dividend_ext;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    // Dividend is total + size - 1, which may carry into bit 32.
    dividend_ext = {1'b0, req.dividend} + {17'd0, req.divisor} - 33'd1;
    trial = {rem_r, quo_r[32]} - {2'b00, dvs_r};
    if (req.start) begin
      quo_nxt  = dividend_ext;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], quo_r[32]};
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[31:0];

endmodule

// ===== sim/tb_batched_update_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_batched_update_frame_receiver: self-checking bench for the frame receiver
// Builds metadata and data frames with random content, predicts stream
// writes, acks, terminal frames and completion, and compares every result.
// ----------------------------------------------------------------------------
module tb_batched_update_frame_receiver;
  import bufr_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  batched_update_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock: 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the receiver state. Names follow what each field holds.
  logic [2:0]  bad_limit;
  logic [15:0] pos;
  logic [15:0] decl_len;
  logic [7:0]  ftype;
  logic        parsing;
  logic [7:0]  sum;
  logic [31:0] pkt_in;
  logic [15:0] pkt_size;
  logic [31:0] xfer_size;
  logic [15:0] batch_len;
  logic [31:0] pkt_count;
  logic [31:0] want_pkt;
  logic [31:0] batch_head;
  logic [31:0] fill;
  logic [31:0] batch_fill;
  logic [15:0] batch_pos;
  logic [2:0]  bad_cnt;
  logic [15:0] stage_pkt_size;
  logic [15:0] stage_batch;

  out_item_t  expected_q[$];
  in_item_t   byte_q[$];
  int         errors;
  int         results_seen;
  int         acks_seen;
  int         terms_seen;
  int         dones_seen;
  int         resp_idx;
  logic [7:0] resp_type;
  bit         quiet_phase;
  bit         hold_req;

  function automatic out_item_t mk(logic [1:0] k, logic [7:0] v, logic [31:0] a,
                                   logic l);
    out_item_t r;
    r.kind = k;
    r.byte_value = v;
    r.stream_address = a;
    r.last = l;
    return r;
  endfunction

  // Serializes one device response frame onto the expected queue.
  task automatic push_response(logic [7:0] ftyp, logic [7:0] pay[], int plen);
    logic [7:0] buf_b[16];
    logic [7:0] s;
    int len;
    len = plen + RESP_FIXED_LEN;
    buf_b[0] = MAGIC_DEV0;
    buf_b[1] = 8'h00;
    buf_b[2] = 8'hee;
    buf_b[3] = ftyp;
    buf_b[4] = len[7:0];
    buf_b[5] = len[15:8];
    for (int i = 0; i < plen; i++) buf_b[6 + i] = pay[i];
    s = 8'h00;
    for (int i = 0; i < len - 1; i++) s = s + buf_b[i];
    buf_b[len - 1] = s;
    for (int i = 0; i < len; i++)
      expected_q.push_back(mk(KIND_RESP, buf_b[i], 32'd0, i == len - 1));
  endtask

  task automatic push_ack(logic [31:0] v);
    logic [7:0] p[];
    p = new[4];
    p[0] = v[7:0]; p[1] = v[15:8]; p[2] = v[23:16]; p[3] = v[31:24];
    push_response(RTYPE_ACK, p, 4);
  endtask

  task automatic note_bad_frame();
    logic [7:0] p[];
    if (bad_cnt < BAD_COUNT_MAX) bad_cnt = bad_cnt + 3'd1;
    if (bad_cnt >= bad_limit) begin
      p = new[1];
      p[0] = 8'h00;
      push_response(RTYPE_TERM, p, 1);
    end else begin
      want_pkt = batch_head;
      fill = batch_fill;
      batch_pos = '0;
      push_ack(batch_head);
    end
  endtask

  task automatic finish_metadata();
    logic [47:0] cnt;
    if (stage_pkt_size == 0 || stage_batch == 0) return;
    pkt_size = stage_pkt_size;
    batch_len = stage_batch;
    xfer_size = pkt_in;
    cnt = ({16'd0, xfer_size} + pkt_size - 48'd1) / pkt_size;
    pkt_count = cnt[31:0];
    want_pkt = '0; batch_head = '0; fill = '0; batch_fill = '0;
    batch_pos = '0; bad_cnt = '0;
    push_ack(32'd0);
  endtask

  task automatic finish_data(logic [7:0] chk);
    if (sum != chk || pkt_in != want_pkt) begin
      note_bad_frame();
      return;
    end
    fill = fill + ({16'd0, decl_len} - {16'd0, DATA_FIXED_LEN});
    want_pkt = want_pkt + 1;
    bad_cnt = '0;
    batch_pos = batch_pos + 16'd1;
    if (pkt_count != 0 && pkt_in == pkt_count - 1) begin
      expected_q.push_back(mk(KIND_DONE, 8'h00, fill, 1'b1));
      return;
    end
    if (batch_len != 0 && batch_pos == batch_len) begin
      push_ack(want_pkt);
      batch_head = want_pkt;
      batch_fill = fill;
      batch_pos = '0;
    end
  endtask

  // Advances the predictor by one accepted frame byte.
  task automatic predict_byte(in_item_t it);
    logic [7:0] b;
    logic [15:0] p;
    b = it.frame_byte;
    if (it.frame_start) begin
      pos = '0; sum = b; parsing = (b == MAGIC_HOST0); ftype = '0; decl_len = '0;
      return;
    end
    if (!parsing) return;
    p = pos + 16'd1;
    pos = p;
    if (p <= 5) begin
      sum = sum + b;
      if (p == 1 && b != MAGIC_HOST1) parsing = 1'b0;
      else if (p == 2 && b != MAGIC_HOST2) parsing = 1'b0;
      else if (p == 3) begin
        ftype = b;
        if (b != FTYPE_META && b != FTYPE_DATA) parsing = 1'b0;
      end else if (p == 4) decl_len = {8'h00, b};
      else if (p == 5) begin
        decl_len = decl_len | {b, 8'h00};
        if (ftype == FTYPE_META && decl_len < META_LENGTH) parsing = 1'b0;
        else if (ftype == FTYPE_DATA && decl_len < DATA_FIXED_LEN) begin
          parsing = 1'b0;
          note_bad_frame();
        end
      end
      return;
    end
    if (p == decl_len - 16'd1) begin
      parsing = 1'b0;
      if (ftype == FTYPE_META) finish_metadata();
      else finish_data(b);
      return;
    end
    sum = sum + b;
    if (ftype == FTYPE_META) begin
      case (p)
        6: stage_pkt_size = {8'h00, b};
        7: stage_pkt_size[15:8] = b;
        8: pkt_in = {24'd0, b};
        9, 10, 11: pkt_in = pkt_in | ({24'd0, b} << ((p - 8) * 8));
        12: stage_batch = {8'h00, b};
        13: stage_batch[15:8] = b;
        default: ;
      endcase
      return;
    end
    if (p == 6) pkt_in = {24'd0, b};
    else if (p <= 9) pkt_in = pkt_in | ({24'd0, b} << ((p - 6) * 8));
    else if (pkt_in == want_pkt)
      expected_q.push_back(mk(KIND_STREAM, b, fill + {16'd0, p} - 32'd10, 1'b0));
  endtask

  // Frame building. Every frame starts with frame_start on its first byte.
  task automatic queue_bytes(logic [7:0] f[]);
    in_item_t it;
    for (int i = 0; i < f.size(); i++) begin
      it.frame_byte = f[i];
      it.frame_start = (i == 0);
      byte_q.push_back(it);
    end
  endtask

  function automatic logic [7:0] checksum(logic [7:0] f[], int n);
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < n; i++) s = s + f[i];
    return s;
  endfunction

  task automatic send_metadata(logic [31:0] xsize, logic [15:0] psize, logic [15:0] bsize);
    logic [7:0] f[];
    f = new[17];
    f[0] = MAGIC_HOST0; f[1] = MAGIC_HOST1; f[2] = MAGIC_HOST2; f[3] = FTYPE_META;
    f[4] = 8'd17; f[5] = 8'd0;
    f[6] = psize[7:0]; f[7] = psize[15:8];
    f[8] = xsize[7:0]; f[9] = xsize[15:8]; f[10] = xsize[23:16]; f[11] = xsize[31:24];
    f[12] = bsize[7:0]; f[13] = bsize[15:8];
    f[14] = 8'($urandom); f[15] = 8'($urandom);
    f[16] = 8'($urandom);  // metadata checksum is not checked
    queue_bytes(f);
  endtask

  // corrupt: 0 good, 1 checksum wrong.
  task automatic send_data(logic [31:0] pnum, int plen, bit corrupt);
    logic [7:0] f[];
    int len;
    len = plen + 11;
    f = new[len];
    f[0] = MAGIC_HOST0; f[1] = MAGIC_HOST1; f[2] = MAGIC_HOST2; f[3] = FTYPE_DATA;
    f[4] = len[7:0]; f[5] = len[15:8];
    f[6] = pnum[7:0]; f[7] = pnum[15:8]; f[8] = pnum[23:16]; f[9] = pnum[31:24];
    for (int i = 0; i < plen; i++) f[10 + i] = 8'($urandom);
    f[len - 1] = checksum(f, len - 1) ^ (corrupt ? 8'h01 : 8'h00);
    queue_bytes(f);
  endtask

  task automatic send_noise(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.frame_byte = 8'($urandom);
      it.frame_start = ($urandom_range(0, 3) == 0);
      byte_q.push_back(it);
    end
  endtask

  // Sender: offers queued bytes with random gaps; payload holds while stalled.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_byte(in_data);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= byte_q.pop_front();
        if (!quiet_phase && $urandom_range(0, 19) == 0) send_gap <= $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  int stall_left;
  int hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_req && hold_left == 0 && !out_stall) begin
      hold_left <= 200;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(1, 13);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      resp_idx = 0;
    end else if (out_valid && !out_stall) begin
      results_seen++;
      if (out_data.kind == KIND_DONE) dones_seen++;
      if (out_data.kind == KIND_RESP) begin
        if (resp_idx == 3) resp_type = out_data.byte_value;
        resp_idx++;
        if (out_data.last) begin
          if (resp_type == RTYPE_ACK) acks_seen++;
          else terms_seen++;
          resp_idx = 0;
        end
      end
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d byte=%h addr=%h last=%0d", $time,
                 out_data.kind, out_data.byte_value, out_data.stream_address,
                 out_data.last);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.kind != want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data.kind);
          errors++;
        end
        if (out_data.byte_value != want.byte_value) begin
          $display("%0t: byte_value expected %h actual %h", $time, want.byte_value,
                   out_data.byte_value);
          errors++;
        end
        if (out_data.stream_address != want.stream_address) begin
          $display("%0t: stream_address expected %h actual %h", $time,
                   want.stream_address, out_data.stream_address);
          errors++;
        end
        if (out_data.last != want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Waits until every queued byte is taken and every expected result is back,
  // then lets the divider and response serializer drain.
  task automatic drain();
    while (byte_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_limit(logic [2:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    bad_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One transfer: metadata then packets, mostly good, some broken.
  task automatic run_transfer(int npkt, int psize, int bsize, int bad_pct);
    int k;
    logic [31:0] xsize;
    xsize = 32'(npkt * psize) - 32'($urandom_range(0, psize - 1));
    send_metadata(xsize, 16'(psize), 16'(bsize));
    k = 0;
    while (k < npkt) begin
      case ($urandom_range(0, 99) < bad_pct ? $urandom_range(0, 3) : 4)
        0: send_data(k, psize, 1'b1);
        1: send_data(k + 1, psize, 1'b0);       // out of sequence
        2: send_noise($urandom_range(1, 6));
        3: begin                                  // truncated by a new start
          send_data(k, psize, 1'b0);
          void'(byte_q.pop_back());
        end
        default: begin
          send_data(k, psize, 1'b0);
          k++;
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] f[];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 3'd0;
    errors = 0; results_seen = 0; dones_seen = 0; acks_seen = 0; terms_seen = 0;
    resp_type = '0;
    quiet_phase = 1'b0;
    hold_req = 1'b0;
    bad_limit = BAD_LIMIT_RESET;
    pos = '0; decl_len = '0; ftype = '0; parsing = 1'b0; sum = '0; pkt_in = '0;
    pkt_size = '0; xfer_size = '0; batch_len = '0; pkt_count = '0; want_pkt = '0;
    batch_head = '0; fill = '0; batch_fill = '0; batch_pos = '0; bad_cnt = '0;
    stage_pkt_size = '0; stage_batch = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: data before any metadata, a short data frame, bad magic,
    // unknown type, short and zero-size metadata, then a tiny transfer with a
    // checksum error and a wrong sequence number.
    send_data(32'd0, 0, 1'b0);
    f = new[6];
    f[0] = MAGIC_HOST0; f[1] = MAGIC_HOST1; f[2] = MAGIC_HOST2; f[3] = FTYPE_DATA;
    f[4] = 8'd10; f[5] = 8'h00;
    queue_bytes(f);
    f[0] = 8'h7f; queue_bytes(f);
    f[0] = MAGIC_HOST0; f[3] = 8'hff; queue_bytes(f);
    f[3] = FTYPE_META; f[4] = 8'd16; queue_bytes(f);
    send_metadata(32'd8, 16'd0, 16'd1);
    send_metadata(32'd8, 16'd4, 16'd0);
    send_noise(3);
    send_metadata(32'd2, 16'd1, 16'd1);
    send_data(32'd0, 1, 1'b1);
    send_data(32'd0, 1, 1'b0);
    send_data(32'd2, 1, 1'b0);
    send_data(32'd1, 1, 1'b0);
    drain();

    // Limit extremes: one bad frame fails at once, zero fails every time,
    // and seven keeps rewinding until the counter saturates.
    write_limit(3'd1);
    send_metadata(32'hffff_ffff, 16'hffff, 16'hffff);
    send_data(32'd0, 1, 1'b1);
    send_data(32'd5, 0, 1'b0);
    drain();
    write_limit(3'd0);
    send_data(32'd9, 1, 1'b0);
    drain();
    write_limit(3'd7);
    for (int i = 0; i < 5; i++) send_data(32'd3, 0, 1'b1);
    drain();

    // Random transfers; the first runs under a long receiver hold-off, the
    // last without any idling.
    for (int t = 0; t < 2; t++) begin
      write_limit(3'($urandom_range(1, 7)));
      if (t == 0) hold_req = 1'b1;
      if (t == 1) quiet_phase = 1'b1;
      run_transfer($urandom_range(2, 3), $urandom_range(1, 2), $urandom_range(1, 2), 25);
      if (t == 0) begin
        wait (hold_left > 0);
        hold_req = 1'b0;
      end
      drain();
    end

    $display("Covered malformed frames, bad frame limits and random transfers:");
    $display("%0d results checked, %0d acks, %0d terminal frames, %0d completions.",
             results_seen, acks_seen, terms_seen, dones_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety limit for a hung handshake.
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bufr_pkg.sv
rtl/bufr_div.sv
rtl/batched_update_frame_receiver.sv
sim/tb_batched_update_frame_receiver.sv
